[hdl/tdf_pkg.sv]
// Shared constants, types and elaboration helpers for the trial division factoriser.
package tdf_pkg;

    localparam int DEF_VALUE_BITS        = 32;
    localparam int DEF_PRIME_TABLE_DEPTH = 8192;
    localparam int DATA_BITS             = 32;
    localparam int MAX_RESULTS           = 32;
    localparam int RESULT_CNT_BITS       = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIVIDE,
        ST_EMIT
    } tdf_state_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } tdf_div_status_t;

    // number of primes below 2**k
    function automatic int prime_count_f(int k);
        int n;
        unique case (k)
            0, 1:    n = 0;
            2:       n = 2;
            3:       n = 4;
            4:       n = 6;
            5:       n = 11;
            6:       n = 18;
            7:       n = 31;
            8:       n = 54;
            9:       n = 97;
            10:      n = 172;
            11:      n = 309;
            12:      n = 564;
            13:      n = 1028;
            14:      n = 1900;
            15:      n = 3512;
            16:      n = 6542;
            17:      n = 12251;
            18:      n = 23000;
            19:      n = 43390;
            default: n = 32'h7fff_ffff;
        endcase
        return n;
    endfunction

    // one past the last prime the search may use, or 2**(value_bits/2) when depth covers every prime below it
    function automatic longint unsigned table_end_f(int value_bits, int depth);
        longint unsigned cand;
        longint unsigned t;
        longint unsigned m;
        int              found;
        bit              is_p;
        found = 0;
        cand  = 64'd1;
        if (depth >= prime_count_f(value_bits / 2)) begin
            return 64'd1 << (value_bits / 2);
        end
        while (found < depth) begin
            cand = cand + 64'd1;
            is_p = 1'b1;
            for (t = 64'd2; (t * t <= cand) && is_p; t = t + 64'd1) begin
                m = t;
                while (m < cand) begin
                    m = m + t;
                end
                if (m == cand) begin
                    is_p = 1'b0;
                end
            end
            if (is_p) begin
                found = found + 1;
            end
        end
        return cand + 64'd1;
    endfunction

endpackage

[hdl/tdf_divider.sv]
// Restoring divider, one quotient bit per cycle, shared by every trial division.
module tdf_divider #(
    parameter int VALUE_BITS   = tdf_pkg::DEF_VALUE_BITS,
    parameter int DIVISOR_BITS = tdf_pkg::DEF_VALUE_BITS / 2 + 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [VALUE_BITS-1:0]     dividend,
    input  logic [DIVISOR_BITS-1:0]   divisor,   // held stable while busy
    output tdf_pkg::tdf_div_status_t  status,
    output logic [VALUE_BITS-1:0]     quotient
);

    localparam int CNT_BITS = $clog2(VALUE_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);

    logic [DIVISOR_BITS-1:0] acc_reg, acc_next;
    logic [VALUE_BITS-1:0]   quo_reg, quo_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    logic [DIVISOR_BITS:0]   shifted;
    logic [DIVISOR_BITS+1:0] diff;
    logic                    fits;

    always_comb begin
        shifted = {acc_reg, quo_reg[VALUE_BITS-1]};
        diff    = {1'b0, shifted} - {2'b00, divisor};
        fits    = ~diff[DIVISOR_BITS+1];

        acc_next  = acc_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
            quo_next = {quo_reg[VALUE_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign status.busy     = busy_reg;
    assign status.done     = done_reg;
    assign status.rem_zero = (acc_reg == '0);
    assign quotient        = quo_reg;

endmodule

[hdl/trial_division_factorizer_top.sv]
// Top level of the trial division prime factoriser.
//
// s_ channel: one request per value to factor (s_tdata). The block takes a
// request only when idle; s_tready stays low until the last factor of the
// previous value has been loaded into the output register.
// m_ channel: one request per prime factor in ascending order with
// multiplicity; m_tlast marks the final factor of a value, m_tuser flags an
// input below two, which is echoed back alone with m_tlast set.
// Trial divisors run 2, 3 and then 6k-1, 6k+1 up to the square root of the
// cofactor, or the end of the prime range set by PRIME_TABLE_DEPTH, and each
// takes one pass of the shared bit-serial divider. When the search ends, the
// final factor passes from ST_TEST through ST_EMIT into the output register.
// Reset (aresetn, synchronous) returns to idle and drops m_tvalid. A stall on
// m_tready holds the factor in the output register; the search runs on and
// waits at the next factor until the held one is taken.
module trial_division_factorizer_top #(
    parameter int VALUE_BITS        = tdf_pkg::DEF_VALUE_BITS,
    parameter int PRIME_TABLE_DEPTH = tdf_pkg::DEF_PRIME_TABLE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tdf_pkg::DATA_BITS-1:0] s_tdata,   // [31:0] value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tdf_pkg::DATA_BITS-1:0] m_tdata,   // [31:0] factor
    output logic                          m_tlast,
    output logic                          m_tuser    // [0] bad_input
);

    localparam int D_BITS  = VALUE_BITS / 2 + 1;
    localparam int SQ_BITS = 2 * D_BITS;
    localparam int CB      = tdf_pkg::RESULT_CNT_BITS;
    localparam logic [D_BITS-1:0] TABLE_END =
        D_BITS'(tdf_pkg::table_end_f(VALUE_BITS, PRIME_TABLE_DEPTH));
    localparam logic [CB-1:0] CNT_LAST = CB'(tdf_pkg::MAX_RESULTS - 1);

    tdf_pkg::tdf_state_t state_reg, state_next;

    logic [VALUE_BITS-1:0]         rem_reg, rem_next;
    logic [D_BITS-1:0]             cand_reg, cand_next;
    logic [SQ_BITS-1:0]            sq_reg, sq_next;
    logic                          step4_reg, step4_next;
    logic [CB-1:0]                 cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0]         pend_fac_reg, pend_fac_next;
    logic                          pend_last_reg, pend_last_next;
    logic                          pend_bad_reg, pend_bad_next;
    logic                          out_valid_reg, out_valid_next;
    logic [tdf_pkg::DATA_BITS-1:0] out_data_reg, out_data_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_bad_reg, out_bad_next;

    logic                     bad_value;
    logic                     search_end;
    logic                     out_free;
    logic                     div_start;
    tdf_pkg::tdf_div_status_t div_status;
    logic [VALUE_BITS-1:0]    div_quotient;

    assign bad_value  = (rem_reg < VALUE_BITS'(2));
    assign search_end = (cand_reg >= TABLE_END) || (sq_reg > SQ_BITS'(rem_reg));
    assign out_free   = ~out_valid_reg | m_tready;

    tdf_divider #(
        .VALUE_BITS  (VALUE_BITS),
        .DIVISOR_BITS(D_BITS)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(rem_reg),
        .divisor (cand_reg),
        .status  (div_status),
        .quotient(div_quotient)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tdf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = tdf_pkg::ST_TEST;
                end
            end
            tdf_pkg::ST_TEST: begin
                if (bad_value || search_end) begin
                    state_next = tdf_pkg::ST_EMIT;
                end else begin
                    state_next = tdf_pkg::ST_DIVIDE;
                end
            end
            tdf_pkg::ST_DIVIDE: begin
                if (div_status.done) begin
                    state_next = div_status.rem_zero ? tdf_pkg::ST_EMIT : tdf_pkg::ST_TEST;
                end
            end
            tdf_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = pend_last_reg ? tdf_pkg::ST_IDLE : tdf_pkg::ST_TEST;
                end
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = (state_reg == tdf_pkg::ST_IDLE);
        div_start = (state_reg == tdf_pkg::ST_TEST) && !bad_value && !search_end;
    end

    // datapath
    always_comb begin
        rem_next       = rem_reg;
        cand_next      = cand_reg;
        sq_next        = sq_reg;
        step4_next     = step4_reg;
        cnt_next       = cnt_reg;
        pend_fac_next  = pend_fac_reg;
        pend_last_next = pend_last_reg;
        pend_bad_next  = pend_bad_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_bad_next   = out_bad_reg;
        out_valid_next = out_valid_reg & ~m_tready;

        unique case (state_reg)
            tdf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    rem_next   = VALUE_BITS'(s_tdata);
                    cand_next  = D_BITS'(2);
                    sq_next    = SQ_BITS'(4);
                    step4_next = 1'b0;
                    cnt_next   = '0;
                end
            end
            tdf_pkg::ST_TEST: begin
                pend_fac_next  = rem_reg;
                pend_last_next = 1'b1;
                pend_bad_next  = bad_value;
            end
            tdf_pkg::ST_DIVIDE: begin
                if (div_status.done) begin
                    if (div_status.rem_zero) begin
                        pend_bad_next = 1'b0;
                        if (cnt_reg == CNT_LAST) begin
                            pend_fac_next  = rem_reg;
                            pend_last_next = 1'b1;
                        end else begin
                            pend_fac_next  = VALUE_BITS'(cand_reg);
                            pend_last_next = (div_quotient == VALUE_BITS'(1));
                            rem_next       = div_quotient;
                            cnt_next       = cnt_reg + 1'b1;
                        end
                    end else begin
                        priority if (cand_reg == D_BITS'(2)) begin
                            cand_next = D_BITS'(3);
                            sq_next   = SQ_BITS'(9);
                        end else if (cand_reg == D_BITS'(3)) begin
                            cand_next = D_BITS'(5);
                            sq_next   = SQ_BITS'(25);
                        end else if (step4_reg) begin
                            cand_next  = cand_reg + D_BITS'(4);
                            sq_next    = sq_reg + (SQ_BITS'(cand_reg) << 3) + SQ_BITS'(16);
                            step4_next = 1'b0;
                        end else begin
                            cand_next  = cand_reg + D_BITS'(2);
                            sq_next    = sq_reg + (SQ_BITS'(cand_reg) << 2) + SQ_BITS'(4);
                            step4_next = 1'b1;
                        end
                    end
                end
            end
            tdf_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = tdf_pkg::DATA_BITS'(pend_fac_reg);
                    out_last_next  = pend_last_reg;
                    out_bad_next   = pend_bad_reg;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tdf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        rem_reg       <= rem_next;
        cand_reg      <= cand_next;
        sq_reg        <= sq_next;
        step4_reg     <= step4_next;
        cnt_reg       <= cnt_next;
        pend_fac_reg  <= pend_fac_next;
        pend_last_reg <= pend_last_next;
        pend_bad_reg  <= pend_bad_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_bad_reg   <= out_bad_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_bad_reg;

    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    a_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == tdf_pkg::ST_DIVIDE))
        else $error("divider result outside divide state");

    a_divisor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tdf_pkg::ST_DIVIDE) |->
            (cand_reg >= D_BITS'(2)) && (sq_reg <= SQ_BITS'(rem_reg)))
        else $error("trial divisor outside square bound");

    a_bad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("bad input echo without last");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the trial division factoriser: directed table, then random values.
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [tdf_pkg::DATA_BITS-1:0] factor;
        logic                          last;
        logic                          bad;
    } factor_t;

    typedef struct {
        logic [tdf_pkg::DATA_BITS-1:0] value;
        bit                            typed;
        logic [tdf_pkg::DATA_BITS-1:0] exp_factor;
        int                            exp_count;
        bit                            exp_bad;
    } stim_row_t;

    localparam int RANDOM_VALUES = 80;
    localparam int LONG_HOLD     = 400;
    localparam int TAIL_CYCLES   = 100;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [tdf_pkg::DATA_BITS-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [tdf_pkg::DATA_BITS-1:0] m_tdata;
    logic                          m_tlast;
    logic                          m_tuser;

    factor_t     pending_factors [$];
    stim_row_t   directed_rows [$];
    int          accepted_count = 0;
    int          mismatch_count = 0;
    int unsigned small_primes [0:15] = '{2, 2, 2, 3, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31,
                                         37, 97};

    trial_division_factorizer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #(64'd200_000_000);
        $display("== FAIL ==");
        $finish;
    end

    // prime factors in ascending order; any divisor works, composites never divide
    function automatic void predict_factors(input logic [tdf_pkg::DATA_BITS-1:0] value);
        longint unsigned rem;
        longint unsigned d;
        factor_t         f;
        rem = 64'(value);
        if (rem < 2) begin
            f.factor = value;
            f.last   = 1'b1;
            f.bad    = 1'b1;
            pending_factors.push_back(f);
            return;
        end
        d = 2;
        while (d <= rem / d) begin
            if (rem % d == 0) begin
                f.factor = d[tdf_pkg::DATA_BITS-1:0];
                f.last   = 1'b0;
                f.bad    = 1'b0;
                pending_factors.push_back(f);
                rem = rem / d;
            end else begin
                d = (d == 2) ? 3 : d + 2;
            end
        end
        f.factor = rem[tdf_pkg::DATA_BITS-1:0];
        f.last   = 1'b1;
        f.bad    = 1'b0;
        pending_factors.push_back(f);
    endfunction

    function automatic stim_row_t row(input logic [tdf_pkg::DATA_BITS-1:0] value,
                                      input bit typed,
                                      input logic [tdf_pkg::DATA_BITS-1:0] exp_factor,
                                      input int exp_count, input bit exp_bad);
        stim_row_t r;
        r.value      = value;
        r.typed      = typed;
        r.exp_factor = exp_factor;
        r.exp_count  = exp_count;
        r.exp_bad    = exp_bad;
        return r;
    endfunction

    // mostly smooth values, some with a cofactor below 2^16, some below 2^18, a few small or bad
    function automatic logic [tdf_pkg::DATA_BITS-1:0] random_value();
        longint unsigned v;
        longint unsigned p;
        int              kind;
        int              n;
        bit              full;
        kind = $urandom_range(0, 99);
        if (kind < 5)
            return $urandom_range(0, 15);
        if (kind < 25)
            return $urandom_range(2, 262143);
        v = 1;
        if (kind >= 70)
            v = 64'($urandom_range(2, 65535));
        n    = $urandom_range(1, 31);
        full = 1'b0;
        while (n > 0 && !full) begin
            p = 64'(small_primes[$urandom_range(0, 15)]);
            if (v * p > 64'hFFFF_FFFF)
                full = 1'b1;
            else
                v = v * p;
            n--;
        end
        return v[tdf_pkg::DATA_BITS-1:0];
    endfunction

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic offer_value(input stim_row_t r, input int gap);
        factor_t f;
        int      k;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r.value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        accepted_count++;
        if (r.typed) begin
            for (k = 0; k < r.exp_count; k++) begin
                f.factor = r.exp_factor;
                f.last   = (k == r.exp_count - 1);
                f.bad    = r.exp_bad;
                pending_factors.push_back(f);
            end
        end else begin
            predict_factors(r.value);
        end
    endtask

    // receiver: random stalls, one long hold-off so the block backs up its input
    initial begin
        int r;
        int hold_cycles;
        bit held;
        held = 1'b0;
        forever begin
            if (!held && accepted_count >= 40) begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++)
                    @(posedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    m_tready <= 1'b1;
                    repeat (200) @(posedge aclk);
                end else if (r < 60) begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge aclk);
                end else if (r < 95) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge aclk);
                end else begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(20, 80)) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        factor_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_factors.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected factor %0d last=%0b bad=%0b", m_tdata, m_tlast,
                             m_tuser);
                mismatch_count++;
            end else begin
                want = pending_factors.pop_front();
                if (m_tdata !== want.factor || m_tlast !== want.last
                        || m_tuser !== want.bad) begin
                    if (mismatch_count < 10)
                        $display({"factor mismatch: expected %0d last=%0b bad=%0b, ",
                                  "got %0d last=%0b bad=%0b"},
                                 want.factor, want.last, want.bad, m_tdata, m_tlast,
                                 m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int i;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // bad inputs, smallest primes, prime powers, largest primes, widest values
        directed_rows.push_back(row(32'd0, 1'b1, 32'd0, 1, 1'b1));
        directed_rows.push_back(row(32'd1, 1'b1, 32'd1, 1, 1'b1));
        directed_rows.push_back(row(32'd2, 1'b1, 32'd2, 1, 1'b0));
        directed_rows.push_back(row(32'd3, 1'b1, 32'd3, 1, 1'b0));
        directed_rows.push_back(row(32'd4, 1'b1, 32'd2, 2, 1'b0));
        directed_rows.push_back(row(32'd49, 1'b1, 32'd7, 2, 1'b0));
        directed_rows.push_back(row(32'h8000_0000, 1'b1, 32'd2, 31, 1'b0));
        directed_rows.push_back(row(32'd65536, 1'b1, 32'd2, 16, 1'b0));
        directed_rows.push_back(row(32'd3486784401, 1'b1, 32'd3, 20, 1'b0));
        directed_rows.push_back(row(32'd65521, 1'b1, 32'd65521, 1, 1'b0));
        // prime above the square of the largest table prime: table runs out
        directed_rows.push_back(row(32'd4294967291, 1'b1, 32'd4294967291, 1, 1'b0));
        directed_rows.push_back(row(32'hFFFF_FFFF, 1'b0, '0, 0, 1'b0));
        directed_rows.push_back(row(32'h5555_5555, 1'b0, '0, 0, 1'b0));
        directed_rows.push_back(row(32'hAAAA_AAAA, 1'b0, '0, 0, 1'b0));
        directed_rows.push_back(row(32'hF000_0000, 1'b0, '0, 0, 1'b0));
        directed_rows.push_back(row(32'd6, 1'b0, '0, 0, 1'b0));
        directed_rows.push_back(row(32'd30030, 1'b0, '0, 0, 1'b0));
        directed_rows.push_back(row(32'd60491, 1'b0, '0, 0, 1'b0));
        directed_rows.push_back(row(32'd1040399, 1'b0, '0, 0, 1'b0));

        foreach (directed_rows[j])
            offer_value(directed_rows[j], random_gap());

        for (i = 0; i < RANDOM_VALUES; i++)
            offer_value(row(random_value(), 1'b0, '0, 0, 1'b0),
                        (i % 25 < 8) ? 0 : random_gap());
        s_tvalid <= 1'b0;

        while (pending_factors.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
hdl/tdf_pkg.sv
hdl/tdf_divider.sv
hdl/trial_division_factorizer_top.sv
tb/testbench.sv
